/* rtl/complex_to_magnitude_phase_assert.svh */
// Assertion macros for the complex to magnitude/phase converter checks.
// Needs a clk and an active-high rst in the scope of each use.
`ifndef COMPLEX_TO_MAGNITUDE_PHASE_ASSERT_SVH
`define COMPLEX_TO_MAGNITUDE_PHASE_ASSERT_SVH

// lbl: when a holds on a clock edge, c holds on that edge too
`define CTMP_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ctmp check failed");

// lbl: when a holds on a clock edge, c holds on a later edge set by n
`define CTMP_ASSERT_DELAY(lbl, a, n, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ##(n) (c)) \
    else $error("ctmp check failed");

`endif

/* rtl/ctmp_pkg.sv */
// Package for the complex to magnitude/phase converter: widths, stage counts,
// arctangent table and pipeline record types. Depends on nothing.
package ctmp_pkg;

  localparam int DATA_WIDTH = 24;
  localparam int ITERATIONS = 24;
  localparam int CW         = 64;
  localparam int ZW         = 34;
  localparam int PHASE_W    = 25;
  localparam int SCALE      = 58 - DATA_WIDTH;
  localparam int RW         = DATA_WIDTH + 2;
  localparam int NSTAGE     = (ITERATIONS > DATA_WIDTH) ? ITERATIONS : DATA_WIDTH;
  localparam int LATENCY    = NSTAGE + 4;

  localparam logic signed [ZW-1:0]      Z_HALF_TURN = 34'sd2147483648;
  localparam logic signed [ZW-1:0]      Z_ROUND     = 34'sd128;
  localparam logic signed [PHASE_W-1:0] PHASE_ONE   = 25'sd8388608;
  localparam logic signed [PHASE_W-1:0] PHASE_MIN   = -25'sd8388607;

  localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81,
    34'sd41,        34'sd20,        34'sd10,        34'sd5,
    34'sd3,         34'sd1,         34'sd1,         34'sd0
  };

  typedef struct packed {
    logic                 byp;
    logic                 bneg;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic [2*DATA_WIDTH-1:0] s;
    logic [DATA_WIDTH-1:0]   root;
    logic [RW-1:0]           rem;
  } sqrt_t;

endpackage

/* rtl/complex_to_magnitude_phase.sv */
// done rises for an accepted sample once it has passed p0, p1, st_valid[0], the
// NSTAGE stage registers and the done register; the result is taken with done.
// Throughput: one sample per cycle, set by one CORDIC step and one square-root
// digit per register stage. busy is high only during reset.
// Reset (rst, synchronous): clears all valid bits; samples in flight are dropped.
module complex_to_magnitude_phase (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [ctmp_pkg::DATA_WIDTH-1:0]  real_part,
  input  logic signed [ctmp_pkg::DATA_WIDTH-1:0]  imag_part,
  output logic                                    done,
  output logic [ctmp_pkg::DATA_WIDTH-1:0]         magnitude,
  output logic signed [ctmp_pkg::PHASE_W-1:0]     phase_over_pi
);

  localparam int DW      = ctmp_pkg::DATA_WIDTH;
  localparam int CW      = ctmp_pkg::CW;
  localparam int ZW      = ctmp_pkg::ZW;
  localparam int RW      = ctmp_pkg::RW;
  localparam int N       = ctmp_pkg::NSTAGE;
  localparam int PHASE_W = ctmp_pkg::PHASE_W;

  logic                  accept;
  logic                  p0_valid;
  ctmp_pkg::cord_t       p0_c;
  logic [DW-1:0]         p0_ar;
  logic [DW-1:0]         p0_ai;
  logic                  p1_valid;
  ctmp_pkg::cord_t       p1_c;
  logic [2*DW-1:0]       p1_sr;
  logic [2*DW-1:0]       p1_si;

  logic                  st_valid [N+1];
  ctmp_pkg::cord_t       st_c     [N+1];
  ctmp_pkg::sqrt_t       st_q     [N+1];
  ctmp_pkg::cord_t       nxt_c    [N];
  ctmp_pkg::sqrt_t       nxt_q    [N];

  ctmp_pkg::cord_t       pre_c;
  logic signed [CW-1:0]  re_x;
  logic signed [CW-1:0]  im_y;
  logic [DW-1:0]         ar;
  logic [DW-1:0]         ai;
  logic signed [ZW-1:0]  z_rnd;
  logic signed [ZW-9:0]  q;
  logic signed [PHASE_W-1:0] ph;
  logic [DW-1:0]         mag;

  assign busy   = rst;
  assign accept = start && !busy;

  // prerotate into the right half plane
  always_comb begin
    re_x = ($signed({{(CW-DW){real_part[DW-1]}}, real_part})) <<< ctmp_pkg::SCALE;
    im_y = ($signed({{(CW-DW){imag_part[DW-1]}}, imag_part})) <<< ctmp_pkg::SCALE;
    ar   = real_part[DW-1] ? (~real_part + 1'b1) : real_part;
    ai   = imag_part[DW-1] ? (~imag_part + 1'b1) : imag_part;
    pre_c.byp  = (imag_part == '0);
    pre_c.bneg = real_part[DW-1];
    if (real_part[DW-1]) begin
      pre_c.x = -re_x;
      pre_c.y = -im_y;
      pre_c.z = (!imag_part[DW-1] && (imag_part != '0)) ? ctmp_pkg::Z_HALF_TURN
                                                        : -ctmp_pkg::Z_HALF_TURN;
    end else begin
      pre_c.x = re_x;
      pre_c.y = im_y;
      pre_c.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
      p1_valid <= 1'b0;
      st_valid[0] <= 1'b0;
    end else begin
      p0_valid <= accept;
      p1_valid <= p0_valid;
      st_valid[0] <= p1_valid;
    end
    p0_c  <= pre_c;
    p0_ar <= ar;
    p0_ai <= ai;
    p1_c  <= p0_c;
    p1_sr <= p0_ar * p0_ar;
    p1_si <= p0_ai * p0_ai;
    st_c[0]      <= p1_c;
    st_q[0].s    <= p1_sr + p1_si;
    st_q[0].root <= '0;
    st_q[0].rem  <= '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k < ctmp_pkg::ITERATIONS) begin : g_cordic
      always_comb begin
        nxt_c[k] = st_c[k];
        if (!st_c[k].y[CW-1]) begin
          nxt_c[k].x = st_c[k].x + (st_c[k].y >>> k);
          nxt_c[k].y = st_c[k].y - (st_c[k].x >>> k);
          nxt_c[k].z = st_c[k].z + ctmp_pkg::ATAN_TAB[k];
        end else begin
          nxt_c[k].x = st_c[k].x - (st_c[k].y >>> k);
          nxt_c[k].y = st_c[k].y + (st_c[k].x >>> k);
          nxt_c[k].z = st_c[k].z - ctmp_pkg::ATAN_TAB[k];
        end
      end
    end else begin : g_cordic_hold
      assign nxt_c[k] = st_c[k];
    end

    if (k < DW) begin : g_sqrt
      logic [RW+1:0] rs;
      logic [RW+1:0] trial;
      always_comb begin
        rs       = {st_q[k].rem, st_q[k].s[2*DW-1 -: 2]};
        trial    = {2'b00, st_q[k].root, 2'b01};
        nxt_q[k] = st_q[k];
        nxt_q[k].s = st_q[k].s << 2;
        if (rs >= trial) begin
          nxt_q[k].rem  = RW'(rs - trial);
          nxt_q[k].root = {st_q[k].root[DW-2:0], 1'b1};
        end else begin
          nxt_q[k].rem  = RW'(rs);
          nxt_q[k].root = {st_q[k].root[DW-2:0], 1'b0};
        end
      end
    end else begin : g_sqrt_hold
      assign nxt_q[k] = st_q[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else begin
        st_valid[k+1] <= st_valid[k];
      end
      st_c[k+1] <= nxt_c[k];
      st_q[k+1] <= nxt_q[k];
    end
  end

  // round phase half up to Q1.23, saturate; round magnitude to nearest
  always_comb begin
    z_rnd = st_c[N].z + ctmp_pkg::Z_ROUND;
    q     = z_rnd[ZW-1:8];
    if (st_c[N].byp) begin
      ph = st_c[N].bneg ? ctmp_pkg::PHASE_ONE : '0;
    end else if (q > (ZW-8)'(ctmp_pkg::PHASE_ONE)) begin
      ph = ctmp_pkg::PHASE_ONE;
    end else if (q < (ZW-8)'(ctmp_pkg::PHASE_MIN)) begin
      ph = ctmp_pkg::PHASE_MIN;
    end else begin
      ph = PHASE_W'(q);
    end
    if (st_q[N].rem > {2'b00, st_q[N].root}) begin
      mag = st_q[N].root + 1'b1;
    end else begin
      mag = st_q[N].root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st_valid[N];
    end
    magnitude     <= mag;
    phase_over_pi <= ph;
  end

endmodule

/* rtl/ctmp_checker.sv */
// Port-level checks for complex_to_magnitude_phase, bound to the top level.
// Depends on ctmp_pkg and complex_to_magnitude_phase_assert.svh.
`include "complex_to_magnitude_phase_assert.svh"

module ctmp_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    start,
  input logic                                    busy,
  input logic signed [ctmp_pkg::DATA_WIDTH-1:0]  real_part,
  input logic signed [ctmp_pkg::DATA_WIDTH-1:0]  imag_part,
  input logic                                    done,
  input logic [ctmp_pkg::DATA_WIDTH-1:0]         magnitude,
  input logic signed [ctmp_pkg::PHASE_W-1:0]     phase_over_pi
);

  `CTMP_ASSERT_DELAY(a_beat_delivered, start && !busy, ctmp_pkg::LATENCY, done)
  `CTMP_ASSERT_IMPL(a_no_spurious_beat, done, $past(start && !busy, ctmp_pkg::LATENCY))
  `CTMP_ASSERT_IMPL(a_phase_range, done, (phase_over_pi <= ctmp_pkg::PHASE_ONE) && (phase_over_pi >= ctmp_pkg::PHASE_MIN))
  `CTMP_ASSERT_IMPL(a_real_axis_zero, done && $past(start && !busy && (imag_part == '0) && !real_part[ctmp_pkg::DATA_WIDTH-1], ctmp_pkg::LATENCY), phase_over_pi == '0)

endmodule

bind complex_to_magnitude_phase ctmp_checker u_ctmp_checker (.*);
